/* hw/rtl/olid_pkg.sv */
package olid_pkg;

    // Largest number of entries the list can hold.
    localparam int DEPTH = 16;

    // Bits for a cell index, for the entry count and for position compares.
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 4) ? CW : 4;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_RANGE = 2'd2
    } t_status;

    // What every cell of the chain does: hold, insert, delete or rotate.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode         mode;
        logic [PW-1:0]      pos;
        logic signed [31:0] value;
    } t_cell_ctrl;

endpackage

/* hw/rtl/ordered_list_insert_delete_top.sv */
// An error beat, or the beat that flags an emptied list, is registered and presented in
// the cycle after acceptance; the first beat of a streamed list passes through the cell
// update and then the output register. After a successful operation a new one is taken
// only once a full turn of the cell ring has brought every entry home and the last beat
// has left the output register, or after an error once its beat is taken; stalls delay it.
// Reset (i_rst_n low, synchronous) empties the list, drops the valid and holds tready low.
module ordered_list_insert_delete_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [3:0] position, [35:4] value, [39:36] zero.
    input  logic [39:0] i_s_axis_tdata,
    // [1:0] command.
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [3:0] entry_index, [35:4] entry_value, [39:36] zero.
    output logic [39:0] o_m_axis_tdata,
    // [1:0] status, [2] list_empty.
    output logic [2:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_STREAM = 3'b010,
        S_SPIN   = 3'b100
    } t_state;

    t_state                    r_state, n_state;
    logic [olid_pkg::CW-1:0]   r_count, n_count;
    logic [olid_pkg::IW-1:0]   r_idx, n_idx;

    // Output register for the result beat.
    logic                      r_m_valid, n_m_valid;
    logic [1:0]                r_status, n_status;
    logic [3:0]                r_index, n_index;
    logic signed [31:0]        r_value, n_value;
    logic                      r_empty, n_empty;
    logic                      r_last, n_last;

    olid_pkg::t_cell_ctrl      w_ctrl;
    logic signed [31:0]        w_cell_q [olid_pkg::DEPTH];

    logic                      w_s_accept;
    logic                      w_out_free;
    logic                      w_is_last;
    logic [1:0]                w_cmd;
    logic [olid_pkg::PW-1:0]   w_pos;
    logic [olid_pkg::PW-1:0]   w_count_ext;
    logic signed [31:0]        w_in_value;

    assign w_cmd       = i_s_axis_tuser;
    assign w_pos       = olid_pkg::PW'(i_s_axis_tdata[3:0]);
    assign w_in_value  = i_s_axis_tdata[35:4];
    assign w_count_ext = olid_pkg::PW'(r_count);

    // New work is taken only out of reset, when the chain is at rest and no
    // beat is pending.
    assign o_s_axis_tready = i_rst_n && (r_state == S_IDLE) && !r_m_valid;
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_m_valid || i_m_axis_tready;
    assign w_is_last       = (olid_pkg::CW'(r_idx) + olid_pkg::CW'(1)) == r_count;

    // The chain of cells. It is closed into a ring so that a rotation by
    // DEPTH places brings every entry past cell zero and back home again.
    for (genvar k = 0; k < olid_pkg::DEPTH; k++) begin : g_cell
        olid_cell u_cell (
            .i_clk   (i_clk),
            .i_index (olid_pkg::IW'(k)),
            .i_ctrl  (w_ctrl),
            .i_left  (w_cell_q[(k + olid_pkg::DEPTH - 1) % olid_pkg::DEPTH]),
            .i_right (w_cell_q[(k + 1) % olid_pkg::DEPTH]),
            .o_value (w_cell_q[k])
        );
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_m_valid = r_m_valid && !i_m_axis_tready;
        n_status  = r_status;
        n_index   = r_index;
        n_value   = r_value;
        n_empty   = r_empty;
        n_last    = r_last;
        w_ctrl.mode  = olid_pkg::CELL_HOLD;
        w_ctrl.pos   = w_pos;
        w_ctrl.value = w_in_value;

        unique case (r_state)
            S_IDLE: begin
                if (w_s_accept) begin
                    unique case (w_cmd) inside
                        olid_pkg::CMD_APPEND, olid_pkg::CMD_INSERT: begin
                            // The full check takes precedence over the range check.
                            if (r_count == olid_pkg::CW'(olid_pkg::DEPTH)) begin
                                n_m_valid = 1'b1;
                                n_status  = olid_pkg::STS_FULL;
                                n_index   = 4'd0;
                                n_value   = 32'sd0;
                                n_empty   = 1'b0;
                                n_last    = 1'b1;
                            end else if ((w_cmd == olid_pkg::CMD_INSERT)
                                         && (w_pos > w_count_ext)) begin
                                n_m_valid = 1'b1;
                                n_status  = olid_pkg::STS_RANGE;
                                n_index   = 4'd0;
                                n_value   = 32'sd0;
                                n_empty   = 1'b0;
                                n_last    = 1'b1;
                            end else begin
                                w_ctrl.mode = olid_pkg::CELL_INSERT;
                                if (w_cmd == olid_pkg::CMD_APPEND) begin
                                    w_ctrl.pos = w_count_ext;
                                end
                                n_count = r_count + olid_pkg::CW'(1);
                                n_idx   = '0;
                                n_state = S_STREAM;
                            end
                        end
                        olid_pkg::CMD_DELETE: begin
                            if (w_pos >= w_count_ext) begin
                                n_m_valid = 1'b1;
                                n_status  = olid_pkg::STS_RANGE;
                                n_index   = 4'd0;
                                n_value   = 32'sd0;
                                n_empty   = 1'b0;
                                n_last    = 1'b1;
                            end else begin
                                w_ctrl.mode = olid_pkg::CELL_DELETE;
                                n_count = r_count - olid_pkg::CW'(1);
                                n_idx   = '0;
                                if (r_count == olid_pkg::CW'(1)) begin
                                    // The list is now empty: one beat flags it.
                                    n_m_valid = 1'b1;
                                    n_status  = olid_pkg::STS_OK;
                                    n_index   = 4'd0;
                                    n_value   = 32'sd0;
                                    n_empty   = 1'b1;
                                    n_last    = 1'b1;
                                end else begin
                                    n_state = S_STREAM;
                                end
                            end
                        end
                        default: begin
                            // The unused command code is dropped without a result.
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_STREAM: begin
                // Cell zero always holds the entry at r_idx; each beat sent
                // rotates the ring by one place.
                if (w_out_free) begin
                    n_m_valid   = 1'b1;
                    n_status    = olid_pkg::STS_OK;
                    n_index     = 4'(r_idx);
                    n_value     = w_cell_q[0];
                    n_empty     = 1'b0;
                    n_last      = w_is_last;
                    w_ctrl.mode = olid_pkg::CELL_ROTATE;
                    n_idx       = r_idx + olid_pkg::IW'(1);
                    if (w_is_last) begin
                        if (r_count == olid_pkg::CW'(olid_pkg::DEPTH)) begin
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_SPIN;
                        end
                    end
                end
            end
            S_SPIN: begin
                // Finish the turn of the ring without output so that every
                // entry returns to its own cell.
                w_ctrl.mode = olid_pkg::CELL_ROTATE;
                if (r_idx == olid_pkg::IW'(olid_pkg::DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + olid_pkg::IW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_m_valid <= n_m_valid;
        end
    end

    // Beat payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_index  <= n_index;
        r_value  <= n_value;
        r_empty  <= n_empty;
        r_last   <= n_last;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {4'd0, r_value, r_index};
    assign o_m_axis_tuser  = {r_empty, r_status};
    assign o_m_axis_tlast  = r_last;

endmodule

/* hw/rtl/olid_cell.sv */
module olid_cell (
    input  logic                       i_clk,
    input  logic [olid_pkg::IW-1:0]    i_index,
    input  olid_pkg::t_cell_ctrl       i_ctrl,
    input  logic signed [31:0]         i_left,
    input  logic signed [31:0]         i_right,
    output logic signed [31:0]         o_value
);

    logic signed [31:0]          r_value;
    logic signed [31:0]          n_value;
    logic [olid_pkg::PW-1:0]     w_index;

    assign w_index = olid_pkg::PW'(i_index);

    // An insert opens a gap at the position by moving later entries up;
    // a delete closes it by pulling later entries down; a rotation moves
    // the whole ring down by one place so that cell zero sees each entry.
    always_comb begin
        n_value = r_value;
        case (i_ctrl.mode)
            olid_pkg::CELL_INSERT: begin
                if (w_index > i_ctrl.pos) begin
                    n_value = i_left;
                end else if (w_index == i_ctrl.pos) begin
                    n_value = i_ctrl.value;
                end
            end
            olid_pkg::CELL_DELETE: begin
                if (w_index >= i_ctrl.pos) begin
                    n_value = i_right;
                end
            end
            olid_pkg::CELL_ROTATE: begin
                n_value = i_right;
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule
